/* design/nfw_pkg.sv */
`default_nettype none

package nfw_pkg;

    // single-precision constants
    localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
    localparam logic [31:0] FP_TWO   = 32'h4000_0000;
    localparam logic [31:0] FP_THREE = 32'h4040_0000;
    localparam logic [31:0] FP_QNAN  = 32'h7FC0_0000;

    // divider: quotient bits, bits per stage, stage count
    localparam int DIV_QBITS     = 26;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_ITER      = DIV_QBITS / DIV_PER_STAGE;

    // unit latencies in cycles
    localparam int DIV_LAT = DIV_ITER + 4;
    localparam int MUL_LAT = 5;
    localparam int ADD_LAT = 8;

    // register indexes of the configuration port
    localparam logic CFG_SCALE_DENSITY = 1'b0;
    localparam logic CFG_SCALE_RADIUS  = 1'b1;

    // operand with hidden bit made explicit and subnormals normalized
    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic signed [11:0] exp;
        logic [23:0]        mant;
    } fp_unp_t;

    // unrounded result: mant[26] is the leading one, mant[2:0] guard/round/sticky
    typedef struct packed {
        logic               special;
        logic [31:0]        sbits;
        logic               sign;
        logic signed [11:0] exp;
        logic [26:0]        mant;
    } fp_raw_t;

    function automatic fp_unp_t fp_unpack(input logic [31:0] x);
        fp_unp_t     u;
        logic [23:0] m;
        logic [4:0]  lz;
        logic        found;
        u.sign = x[31];
        u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        u.zero = (x[30:23] == 8'd0) && (x[22:0] == 23'd0);
        m = (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
        lz = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && m[i]) begin
                found = 1'b1;
                lz = 5'(23 - i);
            end
        end
        u.mant = m << lz;
        u.exp = (x[30:23] == 8'd0) ? (-12'sd126 - $signed({7'd0, lz}))
                                   : ($signed({4'd0, x[30:23]}) - 12'sd127);
        return u;
    endfunction

endpackage

`default_nettype wire

/* design/nfw_profile_residual_jacobian_unit.sv */
`default_nettype none

// NFW profile residual and Jacobian row, one radial bin per beat.
// Input channel: a bin (radius, measured_density, uncertainty, last_bin) is
// taken at a rising edge with start high and busy low; busy stays low, so a
// new bin can enter on every cycle.
// Output channel: done is high for one cycle with residual, deriv_density,
// deriv_radius and final_mark; the receiver cannot hold results off.
// Longest path, from the accepting edge to the edge that ends the done cycle:
// 1 input register, five single-precision divides and one add; the divider's
// 13 two-bit iteration stages set the depth. Throughput: one bin per cycle.
// Configuration: cfg_we writes cfg_wdata to scale_density (index 0) or
// scale_radius (index 1); write only while no bin is in flight.
// Reset: both scale registers return to 1.0 and the pipeline valids clear;
// no clearing pass is needed.
// NaN results are always the quiet NaN 0x7FC00000.

module nfw_profile_residual_jacobian_unit import nfw_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] radius,
    input  wire logic [31:0] measured_density,
    input  wire logic [31:0] uncertainty,
    input  wire logic        last_bin,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    output logic             done,
    output logic      [31:0] residual,
    output logic      [31:0] deriv_density,
    output logic      [31:0] deriv_radius,
    output logic             final_mark
);

    localparam int LATENCY = 1 + 5 * DIV_LAT + ADD_LAT;

    logic        in_valid_reg;
    logic        in_last_reg;
    logic [31:0] radius_reg;
    logic [31:0] rho_reg;
    logic [31:0] sigma_reg;
    logic [31:0] scale_density_reg;
    logic [31:0] scale_radius_reg;

    logic [31:0] rt;
    logic [31:0] ratio;
    logic [31:0] onep;
    logic [31:0] onep_d1;
    logic [31:0] onep_d2;
    logic [31:0] model1;
    logic [31:0] model2;
    logic [31:0] model3;
    logic [31:0] den1;
    logic [31:0] den2;
    logic [31:0] den3;
    logic [31:0] q;
    logic [31:0] fac;
    logic [31:0] ratio_d;
    logic [31:0] p1;
    logic [31:0] p1_d;
    logic [31:0] p2;
    logic [31:0] rho_d;
    logic [31:0] sigma_d;
    logic [31:0] sigma_da;
    logic [31:0] sigma_dm;
    logic [31:0] diff;
    logic [31:0] res;
    logic [31:0] j0;
    logic [31:0] j1;
    logic [1:0]  ctl_out;

    assign busy = 1'b0;

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_last_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            in_last_reg <= last_bin;
        end
    end

    always_ff @(posedge clk)
    begin
        radius_reg <= radius;
        rho_reg <= measured_density;
        sigma_reg <= uncertainty;
    end

    // fit parameter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_density_reg <= FP_ONE;
            scale_radius_reg <= FP_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SCALE_DENSITY: scale_density_reg <= cfg_wdata;
                CFG_SCALE_RADIUS:  scale_radius_reg <= cfg_wdata;
                default:           scale_radius_reg <= scale_radius_reg;
            endcase
        end
    end

    // rt = r/rs and rhos/rs
    nfw_div u_div_rt (.clk(clk), .a(radius_reg), .b(scale_radius_reg), .quot(rt));
    nfw_div u_div_ratio (.clk(clk), .a(scale_density_reg), .b(scale_radius_reg),
                         .quot(ratio));

    // 1 + rt, first divides of model and den
    nfw_add u_add_onep (.clk(clk), .a(FP_ONE), .b(rt), .sum(onep));
    nfw_div u_div_model1 (.clk(clk), .a(scale_density_reg), .b(rt), .quot(model1));
    nfw_div u_div_den1 (.clk(clk), .a(FP_ONE), .b(rt), .quot(den1));

    // second and third divides by 1 + rt
    nfw_delay #(.WIDTH(32), .DEPTH(DIV_LAT - ADD_LAT)) u_dly_onep1 (
        .clk(clk), .rst_n(rst_n), .din(onep), .dout(onep_d1));
    nfw_delay #(.WIDTH(32), .DEPTH(DIV_LAT)) u_dly_onep2 (
        .clk(clk), .rst_n(rst_n), .din(onep_d1), .dout(onep_d2));
    nfw_div u_div_model2 (.clk(clk), .a(model1), .b(onep_d1), .quot(model2));
    nfw_div u_div_den2 (.clk(clk), .a(den1), .b(onep_d1), .quot(den2));
    nfw_div u_div_model3 (.clk(clk), .a(model2), .b(onep_d2), .quot(model3));
    nfw_div u_div_den3 (.clk(clk), .a(den2), .b(onep_d2), .quot(den3));

    // radius factor: rhos/rs * (3 - 2/(1+rt))
    nfw_div u_div_q (.clk(clk), .a(FP_TWO), .b(onep), .quot(q));
    nfw_add u_add_fac (.clk(clk), .a(FP_THREE), .b({~q[31], q[30:0]}), .sum(fac));
    nfw_delay #(.WIDTH(32), .DEPTH(DIV_LAT + 2 * ADD_LAT)) u_dly_ratio (
        .clk(clk), .rst_n(rst_n), .din(ratio), .dout(ratio_d));
    nfw_mul u_mul_p1 (.clk(clk), .a(ratio_d), .b(fac), .prod(p1));
    nfw_delay #(.WIDTH(32), .DEPTH(2 * DIV_LAT - 2 * ADD_LAT - MUL_LAT)) u_dly_p1 (
        .clk(clk), .rst_n(rst_n), .din(p1), .dout(p1_d));
    nfw_mul u_mul_p2 (.clk(clk), .a(p1_d), .b(den3), .prod(p2));

    // measured density and sigma meet the model
    nfw_delay #(.WIDTH(32), .DEPTH(4 * DIV_LAT)) u_dly_rho (
        .clk(clk), .rst_n(rst_n), .din(rho_reg), .dout(rho_d));
    nfw_delay #(.WIDTH(32), .DEPTH(4 * DIV_LAT)) u_dly_sigma (
        .clk(clk), .rst_n(rst_n), .din(sigma_reg), .dout(sigma_d));
    nfw_delay #(.WIDTH(32), .DEPTH(ADD_LAT)) u_dly_sigma_a (
        .clk(clk), .rst_n(rst_n), .din(sigma_d), .dout(sigma_da));
    nfw_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_sigma_m (
        .clk(clk), .rst_n(rst_n), .din(sigma_d), .dout(sigma_dm));

    // weighted residual and Jacobian entries
    nfw_add u_add_diff (.clk(clk), .a(model3), .b({~rho_d[31], rho_d[30:0]}),
                        .sum(diff));
    nfw_div u_div_res (.clk(clk), .a(diff), .b(sigma_da), .quot(res));
    nfw_div u_div_j0 (.clk(clk), .a(den3), .b(sigma_d), .quot(j0));
    nfw_div u_div_j1 (.clk(clk), .a(p2), .b(sigma_dm), .quot(j1));

    // line up the three results and the beat's valid
    nfw_delay #(.WIDTH(32), .DEPTH(ADD_LAT)) u_dly_j0 (
        .clk(clk), .rst_n(rst_n), .din(j0), .dout(deriv_density));
    nfw_delay #(.WIDTH(32), .DEPTH(ADD_LAT - MUL_LAT)) u_dly_j1 (
        .clk(clk), .rst_n(rst_n), .din(j1), .dout(deriv_radius));
    nfw_delay #(.WIDTH(2), .DEPTH(LATENCY - 1)) u_dly_ctl (
        .clk(clk), .rst_n(rst_n), .din({in_valid_reg, in_last_reg}), .dout(ctl_out));

    assign residual = res;
    assign done = ctl_out[1];
    assign final_mark = ctl_out[0];

    // every accepted bin gives exactly one beat after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted bin produced no result beat");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without an accepted bin");

    // NaN results leave in canonical form only
    a_nan_res: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (residual[30:23] == 8'hFF) && (residual[22:0] != 23'd0))
        |-> (residual == FP_QNAN))
        else $error("non-canonical NaN on residual");

    a_nan_j0: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (deriv_density[30:23] == 8'hFF) && (deriv_density[22:0] != 23'd0))
        |-> (deriv_density == FP_QNAN))
        else $error("non-canonical NaN on deriv_density");

    a_nan_j1: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (deriv_radius[30:23] == 8'hFF) && (deriv_radius[22:0] != 23'd0))
        |-> (deriv_radius == FP_QNAN))
        else $error("non-canonical NaN on deriv_radius");

endmodule

`default_nettype wire

/* design/nfw_delay.sv */
`default_nettype none

module nfw_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

/* design/nfw_round.sv */
`default_nettype none

module nfw_round import nfw_pkg::*; (
    input  wire logic        clk,
    input  wire fp_raw_t     raw,
    output logic      [31:0] result
);

    typedef struct packed {
        logic        special;
        logic [31:0] sbits;
        logic        sign;
        logic        ovf;
        logic [7:0]  eb;
        logic [26:0] mant;
    } rnd_stage_t;

    rnd_stage_t         st_reg;
    rnd_stage_t         st_next;
    logic signed [11:0] sh;
    logic [26:0]        lost;
    logic               up;
    logic [30:0]        mag;
    logic [31:0]        result_next;
    logic [31:0]        result_reg;

    // overflow check and subnormal right shift with sticky
    always_comb
    begin
        sh = -12'sd126 - $signed(raw.exp);
        lost = '0;
        st_next.special = raw.special;
        st_next.sbits = raw.sbits;
        st_next.sign = raw.sign;
        st_next.ovf = $signed(raw.exp) > 12'sd127;
        st_next.eb = 8'd0;
        st_next.mant = raw.mant;
        if ($signed(raw.exp) >= -12'sd126)
        begin
            st_next.eb = 8'($signed(raw.exp) + 12'sd127);
        end
        else if (sh >= 12'sd27)
        begin
            st_next.mant = {26'd0, |raw.mant};
        end
        else
        begin
            lost = raw.mant & ~({27{1'b1}} << sh[4:0]);
            st_next.mant = raw.mant >> sh[4:0];
            st_next.mant[0] = st_next.mant[0] | (|lost);
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    // round to nearest even; the carry runs into the exponent field
    always_comb
    begin
        up = st_reg.mant[2] & (st_reg.mant[3] | st_reg.mant[1] | st_reg.mant[0]);
        mag = {st_reg.eb, st_reg.mant[25:3]} + {30'd0, up};
        if (st_reg.special)
        begin
            result_next = st_reg.sbits;
        end
        else if (st_reg.ovf)
        begin
            result_next = {st_reg.sign, 8'hFF, 23'd0};
        end
        else
        begin
            result_next = {st_reg.sign, mag};
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* design/nfw_div.sv */
`default_nettype none

module nfw_div import nfw_pkg::*; (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] quot
);

    typedef struct packed {
        logic               special;
        logic [31:0]        sbits;
        logic               sign;
        logic signed [11:0] exp;
        logic [24:0]        rem;
        logic [25:0]        quo;
        logic [23:0]        dvs;
    } div_stage_t;

    fp_unp_t    ua_reg;
    fp_unp_t    ub_reg;
    div_stage_t stage_reg [DIV_ITER+1];
    div_stage_t stage_next [DIV_ITER+1];
    fp_raw_t    raw;
    logic       sgn;
    logic       lt;

    // unpack
    always_ff @(posedge clk)
    begin
        ua_reg <= fp_unpack(a);
        ub_reg <= fp_unpack(b);
    end

    // special operands, exponent and first partial remainder, then
    // restoring division, two quotient bits per stage
    always_comb
    begin
        div_stage_t t;
        logic       qb;
        sgn = ua_reg.sign ^ ub_reg.sign;
        lt = ua_reg.mant < ub_reg.mant;
        stage_next[0].sign = sgn;
        stage_next[0].special = 1'b1;
        if (ua_reg.nan || ub_reg.nan || (ua_reg.zero && ub_reg.zero)
            || (ua_reg.inf && ub_reg.inf))
        begin
            stage_next[0].sbits = FP_QNAN;
        end
        else if (ua_reg.inf || ub_reg.zero)
        begin
            stage_next[0].sbits = {sgn, 8'hFF, 23'd0};
        end
        else if (ua_reg.zero || ub_reg.inf)
        begin
            stage_next[0].sbits = {sgn, 31'd0};
        end
        else
        begin
            stage_next[0].special = 1'b0;
            stage_next[0].sbits = FP_QNAN;
        end
        stage_next[0].exp = $signed(ua_reg.exp) - $signed(ub_reg.exp)
                            - (lt ? 12'sd1 : 12'sd0);
        stage_next[0].rem = lt ? {ua_reg.mant, 1'b0} : {1'b0, ua_reg.mant};
        stage_next[0].quo = '0;
        stage_next[0].dvs = ub_reg.mant;

        for (int k = 0; k < DIV_ITER; k++)
        begin
            t = stage_reg[k];
            for (int j = 0; j < DIV_PER_STAGE; j++)
            begin
                qb = t.rem >= {1'b0, t.dvs};
                if (qb)
                begin
                    t.rem = t.rem - {1'b0, t.dvs};
                end
                t.quo = {t.quo[24:0], qb};
                t.rem = {t.rem[23:0], 1'b0};
            end
            stage_next[k+1] = t;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_ITER; k++)
        begin
            stage_reg[k] <= stage_next[k];
        end
    end

    // quotient with sticky from the final remainder
    always_comb
    begin
        raw.special = stage_reg[DIV_ITER].special;
        raw.sbits = stage_reg[DIV_ITER].sbits;
        raw.sign = stage_reg[DIV_ITER].sign;
        raw.exp = stage_reg[DIV_ITER].exp;
        raw.mant = {stage_reg[DIV_ITER].quo, |stage_reg[DIV_ITER].rem};
    end

    nfw_round u_round (
        .clk    (clk),
        .raw    (raw),
        .result (quot)
    );

endmodule

`default_nettype wire

/* design/nfw_mul.sv */
`default_nettype none

module nfw_mul import nfw_pkg::*; (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] prod
);

    typedef struct packed {
        logic               special;
        logic [31:0]        sbits;
        logic               sign;
        logic signed [11:0] exp;
        logic [47:0]        prod;
    } mul_stage_t;

    fp_unp_t    ua_reg;
    fp_unp_t    ub_reg;
    mul_stage_t ms_reg;
    mul_stage_t ms_next;
    fp_raw_t    raw_reg;
    fp_raw_t    raw_next;
    logic       sgn;

    // unpack
    always_ff @(posedge clk)
    begin
        ua_reg <= fp_unpack(a);
        ub_reg <= fp_unpack(b);
    end

    // special operands and mantissa product
    always_comb
    begin
        sgn = ua_reg.sign ^ ub_reg.sign;
        ms_next.sign = sgn;
        ms_next.special = 1'b1;
        if (ua_reg.nan || ub_reg.nan || (ua_reg.inf && ub_reg.zero)
            || (ua_reg.zero && ub_reg.inf))
        begin
            ms_next.sbits = FP_QNAN;
        end
        else if (ua_reg.inf || ub_reg.inf)
        begin
            ms_next.sbits = {sgn, 8'hFF, 23'd0};
        end
        else if (ua_reg.zero || ub_reg.zero)
        begin
            ms_next.sbits = {sgn, 31'd0};
        end
        else
        begin
            ms_next.special = 1'b0;
            ms_next.sbits = FP_QNAN;
        end
        ms_next.exp = $signed(ua_reg.exp) + $signed(ub_reg.exp);
        ms_next.prod = ua_reg.mant * ub_reg.mant;
    end

    always_ff @(posedge clk)
    begin
        ms_reg <= ms_next;
    end

    // one-bit normalize and sticky
    always_comb
    begin
        raw_next.special = ms_reg.special;
        raw_next.sbits = ms_reg.sbits;
        raw_next.sign = ms_reg.sign;
        if (ms_reg.prod[47])
        begin
            raw_next.exp = $signed(ms_reg.exp) + 12'sd1;
            raw_next.mant = {ms_reg.prod[47:22], |ms_reg.prod[21:0]};
        end
        else
        begin
            raw_next.exp = ms_reg.exp;
            raw_next.mant = {ms_reg.prod[46:21], |ms_reg.prod[20:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
    end

    nfw_round u_round (
        .clk    (clk),
        .raw    (raw_reg),
        .result (prod)
    );

endmodule

`default_nettype wire

/* design/nfw_add.sv */
`default_nettype none

module nfw_add import nfw_pkg::*; (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] sum
);

    typedef struct packed {
        logic               special;
        logic [31:0]        sbits;
        logic               sign;
        logic               sub;
        logic signed [11:0] exp;
        logic [23:0]        mbig;
        logic [23:0]        msml;
        logic [11:0]        exp_gap;
    } add_swap_t;

    typedef struct packed {
        logic               special;
        logic [31:0]        sbits;
        logic               sign;
        logic               sub;
        logic signed [11:0] exp;
        logic [23:0]        mbig;
        logic [26:0]        sal;
    } add_align_t;

    typedef struct packed {
        logic               special;
        logic [31:0]        sbits;
        logic               sign;
        logic signed [11:0] exp;
        logic [27:0]        total;
        logic [4:0]         lz;
    } add_sum_t;

    fp_unp_t     ua_reg;
    fp_unp_t     ub_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    add_swap_t   sw_reg;
    add_swap_t   sw_next;
    add_align_t  al_reg;
    add_align_t  al_next;
    add_sum_t    sm_reg;
    add_sum_t    sm_next;
    add_sum_t    lz_reg;
    add_sum_t    lz_next;
    fp_raw_t     raw_reg;
    fp_raw_t     raw_next;
    logic        a_big;
    logic [26:0] shifted;
    logic [26:0] lost;
    logic        found;

    // unpack
    always_ff @(posedge clk)
    begin
        ua_reg <= fp_unpack(a);
        ub_reg <= fp_unpack(b);
        a_reg <= a;
        b_reg <= b;
    end

    // special operands and operand swap by magnitude
    always_comb
    begin
        a_big = ($signed(ua_reg.exp) > $signed(ub_reg.exp))
                || ((ua_reg.exp == ub_reg.exp) && (ua_reg.mant >= ub_reg.mant));
        sw_next.special = 1'b1;
        if (ua_reg.nan || ub_reg.nan
            || (ua_reg.inf && ub_reg.inf && (ua_reg.sign != ub_reg.sign)))
        begin
            sw_next.sbits = FP_QNAN;
        end
        else if (ua_reg.inf)
        begin
            sw_next.sbits = {ua_reg.sign, 8'hFF, 23'd0};
        end
        else if (ub_reg.inf)
        begin
            sw_next.sbits = {ub_reg.sign, 8'hFF, 23'd0};
        end
        else if (ua_reg.zero && ub_reg.zero)
        begin
            sw_next.sbits = {ua_reg.sign & ub_reg.sign, 31'd0};
        end
        else if (ua_reg.zero)
        begin
            sw_next.sbits = b_reg;
        end
        else if (ub_reg.zero)
        begin
            sw_next.sbits = a_reg;
        end
        else
        begin
            sw_next.special = 1'b0;
            sw_next.sbits = FP_QNAN;
        end
        sw_next.sub = ua_reg.sign ^ ub_reg.sign;
        sw_next.sign = a_big ? ua_reg.sign : ub_reg.sign;
        sw_next.exp = a_big ? ua_reg.exp : ub_reg.exp;
        sw_next.mbig = a_big ? ua_reg.mant : ub_reg.mant;
        sw_next.msml = a_big ? ub_reg.mant : ua_reg.mant;
        sw_next.exp_gap = a_big ? 12'($signed(ua_reg.exp) - $signed(ub_reg.exp))
                                : 12'($signed(ub_reg.exp) - $signed(ua_reg.exp));
    end

    always_ff @(posedge clk)
    begin
        sw_reg <= sw_next;
    end

    // align the smaller operand with guard, round and sticky
    always_comb
    begin
        shifted = '0;
        lost = '0;
        al_next.special = sw_reg.special;
        al_next.sbits = sw_reg.sbits;
        al_next.sign = sw_reg.sign;
        al_next.sub = sw_reg.sub;
        al_next.exp = sw_reg.exp;
        al_next.mbig = sw_reg.mbig;
        if (sw_reg.exp_gap >= 12'd27)
        begin
            al_next.sal = 27'd1;
        end
        else
        begin
            shifted = {sw_reg.msml, 3'b000} >> sw_reg.exp_gap[4:0];
            lost = {sw_reg.msml, 3'b000} & ~({27{1'b1}} << sw_reg.exp_gap[4:0]);
            al_next.sal = {shifted[26:1], shifted[0] | (|lost)};
        end
    end

    always_ff @(posedge clk)
    begin
        al_reg <= al_next;
    end

    // magnitude add or subtract
    always_comb
    begin
        sm_next.special = al_reg.special;
        sm_next.sbits = al_reg.sbits;
        sm_next.sign = al_reg.sign;
        sm_next.exp = al_reg.exp;
        sm_next.lz = 5'd0;
        if (al_reg.sub)
        begin
            sm_next.total = {1'b0, al_reg.mbig, 3'b000} - {1'b0, al_reg.sal};
        end
        else
        begin
            sm_next.total = {1'b0, al_reg.mbig, 3'b000} + {1'b0, al_reg.sal};
        end
    end

    always_ff @(posedge clk)
    begin
        sm_reg <= sm_next;
    end

    // exact cancellation and leading zero count
    always_comb
    begin
        lz_next = sm_reg;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!found && sm_reg.total[i])
            begin
                found = 1'b1;
                lz_next.lz = 5'(26 - i);
            end
        end
        if (!sm_reg.special && (sm_reg.total == 28'd0))
        begin
            lz_next.special = 1'b1;
            lz_next.sbits = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        lz_reg <= lz_next;
    end

    // normalize
    always_comb
    begin
        raw_next.special = lz_reg.special;
        raw_next.sbits = lz_reg.sbits;
        raw_next.sign = lz_reg.sign;
        if (lz_reg.total[27])
        begin
            raw_next.exp = $signed(lz_reg.exp) + 12'sd1;
            raw_next.mant = {lz_reg.total[27:2], |lz_reg.total[1:0]};
        end
        else
        begin
            raw_next.exp = $signed(lz_reg.exp) - $signed({7'd0, lz_reg.lz});
            raw_next.mant = lz_reg.total[26:0] << lz_reg.lz;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
    end

    nfw_round u_round (
        .clk    (clk),
        .raw    (raw_reg),
        .result (sum)
    );

endmodule

`default_nettype wire
